// File: rtl/qbc_pkg.sv
`timescale 1ns / 1ps
// Package for the quadrature bounded counter: widths, register indexes,
// direction codes and the shared configuration and state structs. No dependencies.
package qbc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int STEP_WIDTH  = COUNT_WIDTH - 1;
    localparam int CFG_IDX_WIDTH = 2;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_COUNT_MIN = 2'd0,
        CFG_COUNT_MAX = 2'd1,
        CFG_STEP_SIZE = 2'd2,
        CFG_ROLL_OVER = 2'd3
    } t_cfg_idx;

    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;

    localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN_RESET = COUNT_WIDTH'(0);
    localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX_RESET = COUNT_WIDTH'(100);
    localparam logic [STEP_WIDTH-1:0]         STEP_SIZE_RESET = STEP_WIDTH'(1);

    typedef struct packed {
        logic signed [COUNT_WIDTH-1:0] count_min;
        logic signed [COUNT_WIDTH-1:0] count_max;
        logic [STEP_WIDTH-1:0]         step_size;
        logic                          roll_over;
    } t_cfg;

    typedef struct packed {
        logic signed [COUNT_WIDTH-1:0] count;
        logic                          prev_both;
        logic                          armed;
        logic signed [1:0]             last_direction;
    } t_state;

endpackage

// File: rtl/qbc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for encoder items, results and register writes.
// Depends on qbc_pkg.
interface qbc_in_if import qbc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic                          a_active;
    logic                          b_active;
    logic signed [COUNT_WIDTH-1:0] load_value;

    modport source (output valid, cmd, a_active, b_active, load_value, input ready);
    modport sink   (input valid, cmd, a_active, b_active, load_value, output ready);
endinterface

interface qbc_out_if import qbc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [COUNT_WIDTH-1:0] count_value;
    logic signed [1:0]             turn_direction;

    modport source (output valid, count_value, turn_direction, input ready);
    modport sink   (input valid, count_value, turn_direction, output ready);
endinterface

interface qbc_cfg_if import qbc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [CFG_IDX_WIDTH-1:0]      index;
    logic [COUNT_WIDTH-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/qbc_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file: limits, step size and roll-over mode.
// Depends on qbc_pkg and qbc_if.
module qbc_cfg_regs import qbc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qbc_cfg_if.sink    i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_min <= COUNT_MIN_RESET;
            r_cfg.count_max <= COUNT_MAX_RESET;
            r_cfg.step_size <= STEP_SIZE_RESET;
            r_cfg.roll_over <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_COUNT_MIN: r_cfg.count_min <= $signed(i_cfg.data);
                CFG_COUNT_MAX: r_cfg.count_max <= $signed(i_cfg.data);
                CFG_STEP_SIZE: r_cfg.step_size <= i_cfg.data[STEP_WIDTH-1:0];
                CFG_ROLL_OVER: r_cfg.roll_over <= i_cfg.data[0];
                default:       r_cfg.roll_over <= r_cfg.roll_over;
            endcase
        end
    end

endmodule

// File: rtl/qbc_step.sv
`timescale 1ns / 1ps
// Next-state logic for one item: a load of the count, or arming, up step, then down step with limits.
// Depends on qbc_pkg.
module qbc_step import qbc_pkg::*; (
    input  t_cfg                          i_cfg,
    input  t_state                        i_state,
    input  logic                          i_cmd,
    input  logic                          i_a_active,
    input  logic                          i_b_active,
    input  logic signed [COUNT_WIDTH-1:0] i_load_value,
    output t_state                        o_state
);

    logic                          both;
    logic                          changed;
    logic                          armed_now;
    logic                          step_up;
    logic                          step_dn;
    logic signed [1:0]             dir_mid;
    logic signed [1:0]             dir_up;
    logic signed [COUNT_WIDTH:0]   min_e;
    logic signed [COUNT_WIDTH:0]   max_e;
    logic signed [COUNT_WIDTH:0]   step_e;
    logic signed [COUNT_WIDTH:0]   sum_up;
    logic signed [COUNT_WIDTH:0]   diff_dn;
    logic signed [COUNT_WIDTH-1:0] count_up;
    logic signed [COUNT_WIDTH:0]   count_up_e;

    // Work one bit wider than the count so the compares cannot overflow.
    assign min_e  = {i_cfg.count_min[COUNT_WIDTH-1], i_cfg.count_min};
    assign max_e  = {i_cfg.count_max[COUNT_WIDTH-1], i_cfg.count_max};
    assign step_e = $signed({2'b00, i_cfg.step_size});

    assign both      = i_a_active & i_b_active;
    assign changed   = both != i_state.prev_both;
    assign armed_now = i_state.armed | (changed & both);
    assign dir_mid   = changed ? i_state.last_direction : DIR_NONE;
    assign step_up   = armed_now & ~i_a_active;
    assign step_dn   = armed_now & ~i_b_active;

    always_comb begin
        sum_up   = {i_state.count[COUNT_WIDTH-1], i_state.count} + step_e;
        count_up = i_state.count;
        dir_up   = dir_mid;
        if (step_up) begin
            if (sum_up < max_e) begin
                count_up = sum_up[COUNT_WIDTH-1:0];
                dir_up   = DIR_UP;
            end else begin
                count_up = i_cfg.roll_over ? i_cfg.count_min : i_cfg.count_max;
            end
        end
        count_up_e = {count_up[COUNT_WIDTH-1], count_up};
        diff_dn    = count_up_e - step_e;

        o_state = i_state;
        if (i_cmd) begin
            o_state.count = i_load_value;
        end else begin
            o_state.prev_both      = changed ? both : i_state.prev_both;
            o_state.armed          = armed_now & ~(step_up | step_dn);
            o_state.count          = count_up;
            o_state.last_direction = dir_up;
            if (step_dn) begin
                if (diff_dn > min_e) begin
                    o_state.count          = diff_dn[COUNT_WIDTH-1:0];
                    o_state.last_direction = DIR_DOWN;
                end else begin
                    o_state.count = i_cfg.roll_over ? i_cfg.count_max : i_cfg.count_min;
                end
            end
        end
    end

endmodule

// File: rtl/quadrature_bounded_counter.sv
`timescale 1ns / 1ps
// Top level of the quadrature bounded counter: input register, step logic,
// result register. Depends on qbc_pkg, qbc_if, qbc_cfg_regs and qbc_step.
//
// Each item on i_in is either a sample of the inverted encoder levels (cmd 0)
// or a load of the count (cmd 1), and produces exactly one result on o_out
// with the count after that item and the turn direction (+1, -1 or 0). The
// block takes one item per cycle unless o_out stalls, and passes each item
// on to o_out through its registers: the item lands in an input register, the
// step logic reads it together with the counter state, and the result
// register holds the outcome. While a result waits to be taken, the input
// register still takes one more item, after which the input stalls. Register
// writes on i_cfg are always ready and take effect on the next cycle; write
// them only while no item is in flight.
module quadrature_bounded_counter import qbc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qbc_in_if.sink    i_in,
    qbc_out_if.source o_out,
    qbc_cfg_if.sink   i_cfg
);

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;

    // Input register
    logic                          r_in_valid;
    logic                          r_cmd;
    logic                          r_a_active;
    logic                          r_b_active;
    logic signed [COUNT_WIDTH-1:0] r_load_value;

    // Result register
    logic                          r_out_valid;
    logic signed [COUNT_WIDTH-1:0] r_count_value;
    logic signed [1:0]             r_turn_direction;

    logic advance;

    // Move the input item forward whenever the result slot is free or drains.
    assign advance    = ~r_out_valid | o_out.ready;
    assign i_in.ready = ~r_in_valid | advance;

    assign o_out.valid          = r_out_valid;
    assign o_out.count_value    = r_count_value;
    assign o_out.turn_direction = r_turn_direction;

    qbc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    qbc_step u_step (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_cmd        (r_cmd),
        .i_a_active   (r_a_active),
        .i_b_active   (r_b_active),
        .i_load_value (r_load_value),
        .o_state      (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid             <= 1'b0;
            r_out_valid            <= 1'b0;
            r_state.count          <= '0;
            r_state.prev_both      <= 1'b0;
            r_state.armed          <= 1'b0;
            r_state.last_direction <= DIR_NONE;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                // Commit the counter state only when a real item passes.
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd        <= i_in.cmd;
            r_a_active   <= i_in.a_active;
            r_b_active   <= i_in.b_active;
            r_load_value <= i_in.load_value;
        end
        if (advance && r_in_valid) begin
            r_count_value    <= n_state.count;
            r_turn_direction <= n_state.last_direction;
        end
    end

endmodule

// File: sim/tb_quadrature_bounded_counter.sv
`timescale 1ns / 1ps
// Self-checking testbench for quadrature_bounded_counter: a queue-fed driver,
// a result monitor and an in-bench model of the detent counter and its limits.
// Depends on qbc_pkg, the qbc_if interfaces and the counter RTL.
module tb_quadrature_bounded_counter;
    import qbc_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 7;
    localparam int IDLE_PCT       = 29;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int PRINT_LIMIT    = 40;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 175;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef struct {
        logic                          cmd;
        logic                          a_active;
        logic                          b_active;
        logic signed [COUNT_WIDTH-1:0] load_value;
    } t_enc_item;

    typedef struct {
        logic signed [COUNT_WIDTH-1:0] count_value;
        logic signed [1:0]             turn_direction;
    } t_count_result;

    // Clock, reset and the signals the testbench drives into the channels.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          drv_valid = 1'b0;
    logic                          drv_cmd   = CMD_SAMPLE;
    logic                          drv_a     = 1'b0;
    logic                          drv_b     = 1'b0;
    logic signed [COUNT_WIDTH-1:0] drv_load  = '0;
    logic                          rcv_ready = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]      cfg_index = '0;
    logic [COUNT_WIDTH-1:0]        cfg_data  = '0;

    qbc_in_if  in_if ();
    qbc_out_if out_if ();
    qbc_cfg_if cfg_if ();

    assign in_if.valid      = drv_valid;
    assign in_if.cmd        = drv_cmd;
    assign in_if.a_active   = drv_a;
    assign in_if.b_active   = drv_b;
    assign in_if.load_value = drv_load;
    assign out_if.ready     = rcv_ready;
    assign cfg_if.valid     = cfg_valid;
    assign cfg_if.index     = cfg_index;
    assign cfg_if.data      = cfg_data;

    quadrature_bounded_counter i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #CLK_HALF clk = ~clk;

    // Model copy of the limits and of the counter state.
    logic signed [COUNT_WIDTH-1:0] lim_min   = COUNT_MIN_RESET;
    logic signed [COUNT_WIDTH-1:0] lim_max   = COUNT_MAX_RESET;
    logic [STEP_WIDTH-1:0]         lim_step  = STEP_SIZE_RESET;
    logic                          lim_wrap  = 1'b0;
    logic signed [COUNT_WIDTH-1:0] mdl_count = '0;
    logic                          mdl_prev_both = 1'b0;
    logic                          mdl_armed = 1'b0;
    logic signed [1:0]             mdl_dir   = DIR_NONE;

    t_enc_item     encoder_items[$];
    t_count_result expected_counts[$];

    logic in_taken      = 1'b0;
    logic no_idle       = 1'b0;
    int   hold_requests = 0;
    int   holds_served  = 0;
    int   hold_left     = 0;
    int   mismatch_count = 0;
    int   items_sent    = 0;
    int   results_seen  = 0;
    int   settings_used = 1;
    int   cycle_count   = 0;

    // Advance the model by one item and return the result it must produce.
    function automatic t_count_result advance_counter(t_enc_item it);
        int            up_sum;
        int            dn_sum;
        logic          both;
        logic          was_armed;
        t_count_result res;
        if (it.cmd == CMD_LOAD) begin
            // Load replaces only the count; arming and direction are kept.
            mdl_count = it.load_value;
        end else begin
            both = it.a_active & it.b_active;
            if (both != mdl_prev_both) begin
                mdl_prev_both = both;
                if (both) begin
                    mdl_armed = 1'b1;
                end
            end else begin
                // Unchanged pair: drop the direction before any step.
                mdl_dir = DIR_NONE;
            end
            was_armed = mdl_armed;
            if (was_armed && !it.a_active) begin
                mdl_armed = 1'b0;
                up_sum = int'(mdl_count) + int'(lim_step);
                if (up_sum < int'(lim_max)) begin
                    mdl_count = up_sum[COUNT_WIDTH-1:0];
                    mdl_dir   = DIR_UP;
                end else begin
                    // Limit hit: the direction stays as it was.
                    mdl_count = lim_wrap ? lim_min : lim_max;
                end
            end
            if (was_armed && !it.b_active) begin
                mdl_armed = 1'b0;
                dn_sum = int'(mdl_count) - int'(lim_step);
                if (dn_sum > int'(lim_min)) begin
                    mdl_count = dn_sum[COUNT_WIDTH-1:0];
                    mdl_dir   = DIR_DOWN;
                end else begin
                    mdl_count = lim_wrap ? lim_max : lim_min;
                end
            end
        end
        res.count_value    = mdl_count;
        res.turn_direction = mdl_dir;
        return res;
    endfunction

    // Predict on every accepted item, check every accepted result.
    always @(posedge clk) begin
        t_enc_item     it;
        t_count_result want;
        in_taken <= rst_n && drv_valid && in_if.ready;
        if (rst_n && cfg_valid && cfg_if.ready) begin
            case (t_cfg_idx'(cfg_index))
                CFG_COUNT_MIN: lim_min  = cfg_data;
                CFG_COUNT_MAX: lim_max  = cfg_data;
                CFG_STEP_SIZE: lim_step = cfg_data[STEP_WIDTH-1:0];
                CFG_ROLL_OVER: lim_wrap = cfg_data[0];
                default: ;
            endcase
        end
        if (rst_n && drv_valid && in_if.ready) begin
            it.cmd        = drv_cmd;
            it.a_active   = drv_a;
            it.b_active   = drv_b;
            it.load_value = drv_load;
            expected_counts.push_back(advance_counter(it));
            items_sent++;
        end
        if (rst_n && out_if.valid && rcv_ready) begin
            results_seen++;
            if (expected_counts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= PRINT_LIMIT) begin
                    $display("%0t: unexpected result count=%0d dir=%0d", $realtime,
                             out_if.count_value, out_if.turn_direction);
                end
            end else begin
                want = expected_counts.pop_front();
                if (out_if.count_value !== want.count_value) begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_LIMIT) begin
                        $display("%0t: count_value expected %0d got %0d", $realtime,
                                 want.count_value, out_if.count_value);
                    end
                end
                if (out_if.turn_direction !== want.turn_direction) begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_LIMIT) begin
                        $display("%0t: turn_direction expected %0d got %0d", $realtime,
                                 want.turn_direction, out_if.turn_direction);
                    end
                end
            end
        end
    end

    // Driver: present the next pending item once the current one is taken.
    always @(negedge clk) begin
        t_enc_item it;
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || in_taken) begin
            if (encoder_items.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                it = encoder_items.pop_front();
                drv_valid <= 1'b1;
                drv_cmd   <= it.cmd;
                drv_a     <= it.a_active;
                drv_b     <= it.b_active;
                drv_load  <= it.load_value;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(negedge clk) begin
        if (!rst_n) begin
            rcv_ready <= 1'b0;
        end else if (hold_left > 0) begin
            rcv_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            rcv_ready    <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_served <= hold_requests;
        end else begin
            rcv_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_sample(logic a, logic b);
        t_enc_item it;
        it.cmd        = CMD_SAMPLE;
        it.a_active   = a;
        it.b_active   = b;
        it.load_value = COUNT_WIDTH'($urandom);
        encoder_items.push_back(it);
    endtask

    task automatic queue_load(logic signed [COUNT_WIDTH-1:0] value);
        t_enc_item it;
        it.cmd        = CMD_LOAD;
        it.a_active   = 1'($urandom_range(1));
        it.b_active   = 1'($urandom_range(1));
        it.load_value = value;
        encoder_items.push_back(it);
    endtask

    // Pick a load value: anywhere, inside the limits, or at or just inside one of them.
    function automatic logic signed [COUNT_WIDTH-1:0] pick_load();
        int lo;
        int hi;
        lo = (lim_min < lim_max) ? int'(lim_min) : int'(lim_max);
        hi = (lim_min < lim_max) ? int'(lim_max) : int'(lim_min);
        case ($urandom_range(3))
            0: return COUNT_WIDTH'($urandom);
            1: return COUNT_WIDTH'(lo + int'($urandom_range(hi - lo)));
            2: return COUNT_WIDTH'(hi - int'($urandom_range(2)));
            default: return COUNT_WIDTH'(lo + int'($urandom_range(2)));
        endcase
    endfunction

    // Mostly full detents (release, press both, release one or both),
    // mixed with loads and random channel noise.
    task automatic queue_random_items(int n);
        int start;
        int pick;
        start = encoder_items.size();
        while (encoder_items.size() - start < n) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                case ($urandom_range(2))
                    0: queue_sample(1'b0, 1'b0);
                    1: queue_sample(1'b0, 1'b1);
                    default: queue_sample(1'b1, 1'b0);
                endcase
                queue_sample(1'b1, 1'b1);
                if ($urandom_range(3) == 0) begin
                    queue_sample(1'b1, 1'b1);
                end
                case ($urandom_range(2))
                    0: queue_sample(1'b0, 1'b1);
                    1: queue_sample(1'b1, 1'b0);
                    default: queue_sample(1'b0, 1'b0);
                endcase
            end else if (pick < 85) begin
                queue_load(pick_load());
            end else begin
                queue_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [COUNT_WIDTH-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write all four registers; unused high bits of step and wrap are random.
    task automatic program_limits(int lo, int hi, int step, logic wrap);
        write_reg(CFG_COUNT_MIN, COUNT_WIDTH'(lo));
        write_reg(CFG_COUNT_MAX, COUNT_WIDTH'(hi));
        write_reg(CFG_STEP_SIZE, {1'($urandom_range(1)), STEP_WIDTH'(step)});
        write_reg(CFG_ROLL_OVER, {(COUNT_WIDTH-1)'($urandom), wrap});
        settings_used++;
        repeat (2) @(posedge clk);
    endtask

    // Hold until every queued item is taken and every result has come back.
    task automatic wait_drain();
        while (encoder_items.size() != 0 || drv_valid || expected_counts.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        int p;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at reset limits 0..100, step 1, saturating.
        queue_sample(1'b0, 1'b0);               // unchanged pair, nothing armed
        queue_sample(1'b1, 1'b1);               // arm
        queue_sample(1'b0, 1'b1);               // step up
        queue_sample(1'b0, 1'b1);               // unchanged, direction clears
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b1, 1'b0);               // down into the minimum: saturate
        queue_load(16'sd99);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b1);               // up into the maximum: saturate
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b1, 1'b1);               // held pressed: clears but stays armed
        queue_sample(1'b1, 1'b0);               // step down
        queue_load(16'sd50);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b0);               // up then down in one sample
        queue_load(-16'sd32768);                // load outside the limits
        queue_load(16'sd32767);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b1, 1'b0);
        queue_load(16'sd0);
        wait_drain();

        // Widest limits, largest step, wrapping.
        program_limits(-32768, 32767, 32767, 1'b1);
        queue_load(16'sd32767);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b1);               // wraps to the minimum
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b1, 1'b0);               // wraps to the maximum
        queue_load(16'sd0);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b0);
        queue_random_items(150);
        wait_drain();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: program_limits(-50, 50, 7, 1'b0);
                1: program_limits(100, -100, 3, 1'b1);     // crossed limits
                2: program_limits(0, 0, 0, 1'b0);          // zero step, one value
                3: program_limits(-32768, 32767, 1, 1'b0);
                4: program_limits(-10, 10, 32767, 1'b1);
                default: program_limits(int'($signed(16'($urandom))),
                                        int'($signed(16'($urandom))),
                                        ($urandom_range(3) == 0) ? int'($urandom_range(32767))
                                                                 : int'($urandom_range(20)),
                                        1'($urandom_range(1)));
            endcase
            no_idle = (p == 3);
            queue_random_items(PHASE_ITEMS);
            // Stall the output long enough that the input backs up too.
            if (p == 4 || p == 7) begin
                hold_requests++;
            end
            wait_drain();
            no_idle = 1'b0;
        end

        $display("Ran %0d encoder items through %0d limit settings, %0d results checked",
                 items_sent, settings_used, results_seen);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
